/* design/cmykc_pkg.sv */
// Shared types, mode codes and a helper function for the CMYK/RGB converter.
// Depends on nothing.
package cmykc_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [3:0][7:0] pix_t;

	typedef enum logic [1:0] {
		MODE_CMYK2RGB = 2'd0,
		MODE_RGB2CMYK = 2'd1,
		MODE_COMPOSE  = 2'd2,
		MODE_PASS     = 2'd3
	} mode_t;

	localparam int unsigned RCP_W     = 24;
	localparam int unsigned RCP_SHIFT = 16;
	localparam byte_t       FULL      = 8'hFF;

	// Fields that ride along the whole pipe
	typedef struct packed {
		mode_t mode;
		pix_t  src;
		pix_t  dst;
		logic  last;
	} side_t;

	// floor(p / 255), exact for p up to 255*255
	function automatic byte_t div255(input logic [15:0] p);
		logic [16:0] sum;
		begin
			sum = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
			return sum[15:8];
		end
	endfunction

endpackage

/* design/cmyk_rgb_convert_compose.sv */
// Top level of the CMYK/RGB converter: eight-stage pixel pipeline.
// Depends on cmykc_pkg.
//
// Usage
//   s_axis carries one pixel per request: source channels 0..3 and the destination
//   CMYK pixel in tdata, the end-of-run marker in tlast. m_axis returns one
//   converted pixel per input pixel, in order, with tlast copied.
//   cfg_wen/cfg_wdata write the mode register: 0 CMYK to RGBA, 1 RGB to CMYK,
//   2 compose RGBA over CMYK, 3 pass the source through. Write it only while the
//   pipe is empty.
// Timing
//   Throughput is one pixel per clock while the receiver keeps m_axis_tready high.
//   Each pixel passes through eight register stages: two for the CMYK to RGB
//   product and divide by 255, two for the alpha blend, and four for the RGB to
//   CMYK minimum, reciprocal lookup, multiply and final select.
// Reset and stalls
//   arst_n clears every stage valid bit and sets the mode to 0. When the receiver
//   holds tready low each stage still fills while the stage ahead of it is empty
//   or moving, so bubbles close up; once the pipe is full s_axis_tready falls and
//   every stage holds its contents.
module cmyk_rgb_convert_compose
	import cmykc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_wdata,     // mode
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// src_ch0, src_ch1, src_ch2, src_ch3, dst_cyan, dst_magenta, dst_yellow, dst_black
	input  logic [63:0] s_axis_tdata,
	input  logic        s_axis_tlast,  // last_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_ch0, out_ch1, out_ch2, out_ch3
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tlast   // last_out
);

	mode_t mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CMYK2RGB;
		end else if (cfg_wen) begin
			mode_q <= mode_t'(cfg_wdata);
		end
	end

	// Reciprocal table: ceil(255 * 2^16 / d); entry 0 is never used
	logic [RCP_W-1:0] rcp_tab [256];

	for (genvar g = 0; g < 256; g++) begin : g_rcp
		localparam int unsigned DIVISOR = (g == 0) ? 1 : g;
		localparam int unsigned RCP =
			((255 << RCP_SHIFT) + DIVISOR - 1) / DIVISOR;
		assign rcp_tab[g] = RCP_W'(RCP);
	end

	// Stage enables: a stage moves when it is empty or the next one moves
	logic en1, en2, en3, en4, en5, en6, en7, en8;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	assign en8 = !vld_s8 || m_axis_tready;
	assign en7 = !vld_s7 || en8;
	assign en6 = !vld_s6 || en7;
	assign en5 = !vld_s5 || en6;
	assign en4 = !vld_s4 || en5;
	assign en3 = !vld_s3 || en4;
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;

	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= s_axis_tvalid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
			if (en6) vld_s6 <= vld_s5;
			if (en7) vld_s7 <= vld_s6;
			if (en8) vld_s8 <= vld_s7;
		end
	end

	// Stage 1: (255-x)(255-k) on source CMYK in mode 0, destination otherwise
	side_t side_in;
	side_t side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;
	logic [2:0][15:0] prod_s1;
	pix_t cmyk_sel;

	always_comb begin
		side_in.mode = mode_q;
		side_in.src  = s_axis_tdata[31:0];
		side_in.dst  = s_axis_tdata[63:32];
		side_in.last = s_axis_tlast;
		cmyk_sel = (mode_q == MODE_CMYK2RGB) ? side_in.src : side_in.dst;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			side_s1 <= side_in;
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= (16'(FULL - cmyk_sel[i])) * (16'(FULL - cmyk_sel[3]));
			end
		end
	end

	// Stage 2: divide by 255
	pix_t c2r_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			side_s2 <= side_s1;
			for (int i = 0; i < 3; i++) begin
				c2r_s2[i] <= div255(prod_s1[i]);
			end
			c2r_s2[3] <= FULL;
		end
	end

	// Stage 3: alpha times the channel distance
	pix_t c2r_s3;
	logic [2:0][15:0] bprod_s3;
	logic [2:0] ge_s3;
	byte_t diff [3];
	logic  ge [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ge[i]   = side_s2.src[i] >= c2r_s2[i];
			diff[i] = ge[i] ? side_s2.src[i] - c2r_s2[i] : c2r_s2[i] - side_s2.src[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			side_s3 <= side_s2;
			c2r_s3  <= c2r_s2;
			for (int i = 0; i < 3; i++) begin
				ge_s3[i]    <= ge[i];
				bprod_s3[i] <= 16'(side_s2.src[3]) * 16'(diff[i]);
			end
		end
	end

	// Stage 4: finish the blend and pick the RGB that goes back to CMYK
	pix_t c2r_s4;
	logic [2:0][7:0] rgb_s4;
	logic use_src;
	byte_t bq [3];

	always_comb begin
		use_src = (side_s3.mode != MODE_COMPOSE) || (side_s3.src[3] == FULL);
		for (int i = 0; i < 3; i++) begin
			bq[i] = div255(bprod_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			side_s4 <= side_s3;
			c2r_s4  <= c2r_s3;
			for (int i = 0; i < 3; i++) begin
				if (use_src) begin
					rgb_s4[i] <= side_s3.src[i];
				end else if (ge_s3[i]) begin
					rgb_s4[i] <= c2r_s3[i] + bq[i];
				end else begin
					rgb_s4[i] <= c2r_s3[i] - bq[i];
				end
			end
		end
	end

	// Stage 5: invert and take the minimum as black
	pix_t c2r_s5;
	logic [2:0][7:0] inv_s5;
	byte_t k_s5;
	byte_t inv [3];
	byte_t kmin;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			inv[i] = FULL - rgb_s4[i];
		end
		kmin = (inv[0] < inv[1]) ? inv[0] : inv[1];
		kmin = (inv[2] < kmin) ? inv[2] : kmin;
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			side_s5 <= side_s4;
			c2r_s5  <= c2r_s4;
			k_s5    <= kmin;
			for (int i = 0; i < 3; i++) begin
				inv_s5[i] <= inv[i];
			end
		end
	end

	// Stage 6: numerator and reciprocal of (255 - K)
	pix_t c2r_s6;
	logic [2:0][7:0] v_s6;
	logic [RCP_W-1:0] rcp_s6;
	byte_t k_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			side_s6 <= side_s5;
			c2r_s6  <= c2r_s5;
			k_s6    <= k_s5;
			rcp_s6  <= rcp_tab[FULL - k_s5];
			for (int i = 0; i < 3; i++) begin
				v_s6[i] <= inv_s5[i] - k_s5;
			end
		end
	end

	// Stage 7: scaled quotient by reciprocal multiply
	pix_t c2r_s7;
	logic [2:0][31:0] q_s7;
	byte_t k_s7;

	always_ff @(posedge clk) begin
		if (en7) begin
			side_s7 <= side_s6;
			c2r_s7  <= c2r_s6;
			k_s7    <= k_s6;
			for (int i = 0; i < 3; i++) begin
				q_s7[i] <= 32'(v_s6[i]) * 32'(rcp_s6);
			end
		end
	end

	// Stage 8: output register and per-mode select
	pix_t cmyk;
	pix_t res;
	pix_t out_s8;
	logic last_s8;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cmyk[i] = (k_s7 == FULL) ? 8'd0 : q_s7[i][RCP_SHIFT+7:RCP_SHIFT];
		end
		cmyk[3] = k_s7;
		case (side_s7.mode)
			MODE_CMYK2RGB: res = c2r_s7;
			MODE_RGB2CMYK: res = cmyk;
			MODE_COMPOSE:  res = (side_s7.src[3] == 8'd0) ? side_s7.dst : cmyk;
			default:       res = side_s7.src;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en8) begin
			out_s8  <= res;
			last_s8 <= side_s7.last;
		end
	end

	assign m_axis_tvalid = vld_s8;
	assign m_axis_tdata  = out_s8;
	assign m_axis_tlast  = last_s8;

endmodule

/* tb/cmyk_rgb_convert_compose_test.sv */
// Self-checking bench for cmyk_rgb_convert_compose: all four modes, extremes, compose alpha
// cases, random pixels with random idling on both streams and a long receiver hold-off.
// Depends on cmykc_pkg and the converter RTL.
module cmyk_rgb_convert_compose_test;
	import cmykc_pkg::*;

	typedef struct {
		pix_t pix;
		logic last;
	} pixel_exp_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [1:0]  cfg_wdata;        // mode
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// src_ch0, src_ch1, src_ch2, src_ch3, dst_cyan, dst_magenta, dst_yellow, dst_black
	logic [63:0] s_axis_tdata;
	logic        s_axis_tlast;     // last_in
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// out_ch0, out_ch1, out_ch2, out_ch3
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;     // last_out

	pixel_exp_t expected_pixels[$];
	pixel_exp_t head;
	mode_t      cur_mode = MODE_CMYK2RGB;
	bit         tx_idle_on = 1'b0;
	bit         rx_idle_on = 1'b0;
	int         hold_cycles = 0;
	int         error_count = 0;
	int         pixels_sent = 0;
	int         results_checked = 0;
	int         mode_pixels[4] = '{0, 0, 0, 0};

	cmyk_rgb_convert_compose u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------- pixel maths

	function automatic int unsigned cmyk_chan_rgb(input int unsigned x, input int unsigned k);
		return ((255 - x) * (255 - k)) / 255;
	endfunction

	function automatic pix_t cmyk_from_rgb(input byte_t r, input byte_t g, input byte_t b);
		int unsigned inv[3];
		int unsigned k;
		pix_t res;
		inv[0] = 255 - r;
		inv[1] = 255 - g;
		inv[2] = 255 - b;
		k = 255;
		for (int i = 0; i < 3; i++)
			if (inv[i] < k)
				k = inv[i];
		for (int i = 0; i < 3; i++)
			res[i] = (k == 255) ? 8'd0 : 8'(((inv[i] - k) * 255) / (255 - k));
		res[3] = 8'(k);
		return res;
	endfunction

	// truncate the blend step towards zero on either side of the destination
	function automatic byte_t alpha_mix(input int unsigned s, input int unsigned d,
			input int unsigned a);
		if (s >= d)
			return 8'(d + (a * (s - d)) / 255);
		return 8'(d - (a * (d - s)) / 255);
	endfunction

	function automatic pix_t converted_pixel(input mode_t m, input logic [63:0] px);
		pix_t src;
		pix_t dst;
		pix_t res;
		byte_t mixed[3];
		src = px[31:0];
		dst = px[63:32];
		case (m)
			MODE_CMYK2RGB: begin
				for (int i = 0; i < 3; i++)
					res[i] = 8'(cmyk_chan_rgb(src[i], src[3]));
				res[3] = FULL;
			end
			MODE_RGB2CMYK: begin
				res = cmyk_from_rgb(src[0], src[1], src[2]);
			end
			MODE_COMPOSE: begin
				if (src[3] == 8'd0) begin
					res = dst;
				end else if (src[3] == FULL) begin
					res = cmyk_from_rgb(src[0], src[1], src[2]);
				end else begin
					for (int i = 0; i < 3; i++)
						mixed[i] = alpha_mix(src[i], cmyk_chan_rgb(dst[i], dst[3]), src[3]);
					res = cmyk_from_rgb(mixed[0], mixed[1], mixed[2]);
				end
			end
			default: begin
				res = src;
			end
		endcase
		return res;
	endfunction

	function automatic logic [63:0] pack_pixel(input byte_t s0, input byte_t s1, input byte_t s2,
			input byte_t s3, input byte_t d0, input byte_t d1, input byte_t d2, input byte_t d3);
		return {d3, d2, d1, d0, s3, s2, s1, s0};
	endfunction

	function automatic logic [63:0] random_pixel(input mode_t m);
		logic [63:0] px;
		px = {$urandom, $urandom};
		// bias towards the corner cases of each mode
		case ($urandom_range(0, 9))
			0: px[31:24] = 8'h00;
			1: px[31:24] = 8'hff;
			2: px[23:0] = 24'h000000;
			3: px[23:0] = 24'hffffff;
			4: px[23:8] = {px[7:0], px[7:0]};
			5: px[63:56] = 8'hff;
			default: ;
		endcase
		if (m == MODE_COMPOSE && $urandom_range(0, 3) == 0)
			px[31:24] = $urandom_range(0, 1) ? 8'hff : 8'h00;
		return px;
	endfunction

	// ---------------------------------------------------------------- stream drivers

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 50)
			$display("MISMATCH at result %0d: %s", results_checked, msg);
	endtask

	task automatic send_pixel(input logic [63:0] px, input logic last);
		pixel_exp_t want;
		@(negedge clk);
		if (tx_idle_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		want.pix  = converted_pixel(cur_mode, px);
		want.last = last;
		expected_pixels.push_back(want);
		pixels_sent++;
		mode_pixels[cur_mode]++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_mode(input mode_t m);
		wait_drained();
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cur_mode = m;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic send_random(input int count);
		for (int n = 0; n < count; n++)
			send_pixel(random_pixel(cur_mode), $urandom_range(0, 7) == 0);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_reset_mode();
		// no write yet: mode comes from reset
		send_pixel(pack_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
		send_pixel(pack_pixel(8'hff, 8'hff, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff), 1'b0);
		send_pixel(pack_pixel(8'h00, 8'h00, 8'h00, 8'hff, 8'h5a, 8'ha5, 8'h33, 8'hcc), 1'b0);
		send_pixel(pack_pixel(8'hff, 8'h00, 8'h80, 8'h01, 8'h12, 8'h34, 8'h56, 8'h78), 1'b1);
		send_pixel(pack_pixel(8'h0c, 8'hc8, 8'h4d, 8'h64, 8'h00, 8'hff, 8'h00, 8'hff), 1'b0);
	endtask

	task automatic test_rgb_to_cmyk();
		write_mode(MODE_RGB2CMYK);
		send_pixel(pack_pixel(8'h00, 8'h00, 8'h00, 8'h7e, 8'hff, 8'h00, 8'hff, 8'h00), 1'b0);
		send_pixel(pack_pixel(8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1);
		send_pixel(pack_pixel(8'hff, 8'h00, 8'h00, 8'hff, 8'h11, 8'h22, 8'h33, 8'h44), 1'b0);
		send_pixel(pack_pixel(8'h01, 8'h02, 8'h03, 8'haa, 8'hde, 8'had, 8'hbe, 8'hef), 1'b0);
		send_pixel(pack_pixel(8'hfe, 8'hfe, 8'hfe, 8'h55, 8'hff, 8'hff, 8'hff, 8'hff), 1'b1);
	endtask

	task automatic test_compose();
		write_mode(MODE_COMPOSE);
		// zero alpha keeps the destination, full alpha converts the source
		send_pixel(pack_pixel(8'h9c, 8'h21, 8'he7, 8'h00, 8'hff, 8'h00, 8'h80, 8'h07), 1'b0);
		send_pixel(pack_pixel(8'hff, 8'h00, 8'h00, 8'hff, 8'h3c, 8'hc3, 8'h18, 8'h81), 1'b0);
		send_pixel(pack_pixel(8'hff, 8'hff, 8'hff, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00), 1'b0);
		send_pixel(pack_pixel(8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1);
		send_pixel(pack_pixel(8'h6b, 8'hd0, 8'h15, 8'hfe, 8'hff, 8'hff, 8'hff, 8'hff), 1'b0);
		send_pixel(pack_pixel(8'h40, 8'hc0, 8'h20, 8'h4d, 8'h10, 8'h90, 8'hf0, 8'h30), 1'b1);
	endtask

	task automatic test_passthrough();
		write_mode(MODE_PASS);
		send_pixel(pack_pixel(8'hff, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1);
		send_pixel(pack_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff), 1'b0);
		write_mode(MODE_CMYK2RGB);
		send_pixel(pack_pixel(8'h80, 8'h7f, 8'h01, 8'hfe, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1);
		send_pixel(pack_pixel(8'hfe, 8'h01, 8'h7f, 8'h80, 8'hff, 8'hff, 8'hff, 8'hff), 1'b0);
	endtask

	task automatic test_random_modes();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		for (int p = 0; p < 8; p++) begin
			write_mode(mode_t'(p % 4));
			send_random($urandom_range(110, 150));
		end
	endtask

	task automatic test_backpressure();
		write_mode(MODE_COMPOSE);
		tx_idle_on  = 1'b0;
		rx_idle_on  = 1'b0;
		// receiver holds off while the pipe fills and its input stalls
		hold_cycles = 60;
		send_random(40);
		// pause the sender until the pipe has emptied
		wait_drained();
		send_random(20);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic test_full_rate();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		write_mode(MODE_RGB2CMYK);
		send_random(150);
		write_mode(MODE_COMPOSE);
		send_random(150);
	endtask

	// ---------------------------------------------------------------- receiver and checker

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
				m_axis_tready <= 1'b1;
			end else if (rx_idle_on && $urandom_range(0, 6) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing outstanding", m_axis_tdata));
			end else begin
				head = expected_pixels.pop_front();
				for (int ch = 0; ch < 4; ch++)
					if (m_axis_tdata[ch*8 +: 8] !== head.pix[ch])
						report_mismatch($sformatf("out_ch%0d got %0d want %0d", ch,
							m_axis_tdata[ch*8 +: 8], head.pix[ch]));
				if (m_axis_tlast !== head.last)
					report_mismatch($sformatf("last_out got %b want %b", m_axis_tlast,
						head.last));
				results_checked++;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n        = 1'b0;
		cfg_wen       = 1'b0;
		cfg_wdata     = MODE_CMYK2RGB;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		test_reset_mode();
		test_rgb_to_cmyk();
		test_compose();
		test_passthrough();
		test_random_modes();
		test_backpressure();
		test_full_rate();

		wait_drained();
		repeat (16) @(posedge clk);
		$display("%0d pixels sent, %0d results checked, %0d mismatches", pixels_sent,
			results_checked, error_count);
		$display("per mode: cmyk->rgba %0d, rgb->cmyk %0d, compose %0d, pass %0d",
			mode_pixels[0], mode_pixels[1], mode_pixels[2], mode_pixels[3]);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule

/* filelist.f */
design/cmykc_pkg.sv
design/cmyk_rgb_convert_compose.sv
tb/cmyk_rgb_convert_compose_test.sv
